// ===== src/rtct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_pkg
// Shared types and constants for the range toggle / count tree.
// ----------------------------------------------------------------------------
package rtct_pkg;

  // Field widths of the item and result ports
  localparam int unsigned POS_W = 17;
  localparam int unsigned OUT_W = 17;
  localparam int unsigned LEN_W = 17;

  // Default tree size and reset length
  localparam int unsigned DEF_NUM_LEAVES = 65536;
  localparam logic [LEN_W-1:0] RST_ACTIVE_LEN = LEN_W'(65536);

  // Operation codes
  typedef enum logic {
    CMD_TOGGLE = 1'b0,
    CMD_COUNT  = 1'b1
  } cmd_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_RET   = 5'b10000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic eval;
    logic ret;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic empty;
    logic partial;
    logic stack_empty;
    logic top_phase;
  } dp_stat_t;

endpackage

// ===== src/range_toggle_count_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_toggle_count_tree
// Range toggle and range ones-count over a row of bits, held as a tree of
// ones-counts with flip marks in one node memory.
// ----------------------------------------------------------------------------
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+------------------
//  item    | in_cmd, in_range_first, in_range_last        | start & !busy
//  result  | out_on_count                                 | out_valid strobe
//  config  | cfg_active_len                               | cfg_we
//
// Each visited node takes a memory read, an evaluate step and a return
// step. A range that splits P nodes visits 2P+1 of them. After reset a
// clearing pass zeroes the node memory with busy high. Results are a
// one-cycle strobe; the receiver cannot stall. NUM_LEAVES is a power of
// two.
// ----------------------------------------------------------------------------
module range_toggle_count_tree #(
  parameter int unsigned NUM_LEAVES = rtct_pkg::DEF_NUM_LEAVES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [rtct_pkg::POS_W-1:0] in_range_first,
  input  logic [rtct_pkg::POS_W-1:0] in_range_last,
  output logic                       out_valid,
  output logic [rtct_pkg::OUT_W-1:0] out_on_count,
  input  logic                       cfg_we,
  input  logic [rtct_pkg::LEN_W-1:0] cfg_active_len
);
  import rtct_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rtct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rtct_dp #(
    .NUM_LEAVES (NUM_LEAVES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_range_first (in_range_first),
    .in_range_last  (in_range_last),
    .cfg_we         (cfg_we),
    .cfg_active_len (cfg_active_len),
    .out_valid      (out_valid),
    .out_on_count   (out_on_count)
  );

endmodule

// ===== src/rtct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rtct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rtct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_ctrl
// Sequencer for the clearing pass and the node-by-node tree walk.
// ----------------------------------------------------------------------------
module rtct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rtct_pkg::dp_stat_t  stat,
  output rtct_pkg::ctrl_cmd_t cmd,
  output logic                busy
);
  import rtct_pkg::*;

  state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = stat.empty ? S_RET : S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.partial ? S_READ : S_RET;
      end
      S_RET: begin
        cmd.ret = 1'b1;
        if (stat.stack_empty) state_nxt = S_IDLE;
        else if (!stat.top_phase) state_nxt = S_READ;
        else state_nxt = S_RET;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== src/rtct_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_dp
// Tree walk datapath: node memory, frame stack, range compare and counts.
// ----------------------------------------------------------------------------
module rtct_dp #(
  parameter int unsigned NUM_LEAVES = rtct_pkg::DEF_NUM_LEAVES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rtct_pkg::ctrl_cmd_t         cmd,
  output rtct_pkg::dp_stat_t          stat,
  input  logic                        in_cmd,
  input  logic [rtct_pkg::POS_W-1:0]  in_range_first,
  input  logic [rtct_pkg::POS_W-1:0]  in_range_last,
  input  logic                        cfg_we,
  input  logic [rtct_pkg::LEN_W-1:0]  cfg_active_len,
  output logic                        out_valid,
  output logic [rtct_pkg::OUT_W-1:0]  out_on_count
);
  import rtct_pkg::*;

  localparam int unsigned LOG = $clog2(NUM_LEAVES);      // tree height
  localparam int unsigned PW  = LOG + 1;                 // position + size
  localparam int unsigned AW  = LOG + 1;                 // node address
  localparam int unsigned CNW = LOG + 1;                 // node ones-count
  localparam int unsigned LW  = $clog2(LOG + 1);         // level code
  localparam int unsigned IW  = (PW > POS_W) ? PW : POS_W;
  localparam int unsigned SD  = LOG + 1;                 // stack depth
  localparam int unsigned SIW = $clog2(SD);
  localparam int unsigned SPW = $clog2(SD + 1);
  localparam int unsigned MW  = CNW + 1;                 // {flag, count}

  // Configuration register
  logic [LEN_W-1:0] active_len_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_len_r <= RST_ACTIVE_LEN;
    end else if (cfg_we) begin
      active_len_r <= cfg_active_len;
    end
  end

  // Clip the incoming range
  logic [IW-1:0] len_c, first_c, last_c, first_x, last_x, alen_x;
  always_comb begin
    alen_x  = IW'(active_len_r);
    first_x = IW'(in_range_first);
    last_x  = IW'(in_range_last);
    len_c   = (alen_x > IW'(NUM_LEAVES)) ? IW'(NUM_LEAVES) : alen_x;
    first_c = (first_x == '0) ? IW'(1) : first_x;
    last_c  = (last_x > len_c) ? len_c : last_x;
  end
  assign stat.empty = (len_c == '0) || (first_c > last_c);

  // Item registers
  logic           op_r;
  logic [LOG-1:0] lo_r, hi_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_cmd;
      lo_r <= LOG'(first_c - IW'(1));
      hi_r <= LOG'(last_c - IW'(1));
    end
  end

  // Clearing pass counter
  logic [AW-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end
  assign stat.clr_last = (clr_addr_r == {AW{1'b1}});

  // Current visit
  logic [AW-1:0]  v_node_r, v_node_nxt;
  logic [LOG-1:0] v_s_r, v_s_nxt;
  logic [LW-1:0]  v_lvl_r, v_lvl_nxt;
  logic           v_par_r, v_par_nxt;

  // Frame stack
  logic [AW-1:0]  stk_node_r  [SD];
  logic [LOG-1:0] stk_s_r     [SD];
  logic [LW-1:0]  stk_lvl_r   [SD];
  logic           stk_flag_r  [SD];
  logic           stk_cpar_r  [SD];
  logic [CNW-1:0] stk_lc_r    [SD];
  logic           stk_phase_r [SD];
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [SIW-1:0] push_idx, top_idx;

  logic [CNW-1:0] acc_r, acc_nxt, ret_cnt_r, ret_cnt_nxt;
  logic           outv_r, outv_nxt;
  logic [OUT_W-1:0] outc_r, outc_nxt;

  // Node memory
  logic           m_we;
  logic [AW-1:0]  m_waddr;
  logic [MW-1:0]  m_wdata, m_rdata;
  logic [CNW-1:0] rcnt;
  logic           rflag;

  rtct_ram #(
    .WIDTH (MW),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (cmd.rd),
    .raddr (v_node_r),
    .rdata (m_rdata)
  );
  assign rcnt  = m_rdata[CNW-1:0];
  assign rflag = m_rdata[CNW];

  // Range compare for the visited node
  logic [PW-1:0] v_size, v_end, top_size, sum_c, fixed_c;
  logic          disj, full, is_toggle, top_ph;
  always_comb begin
    v_size = PW'(1) << v_lvl_r;
    v_end  = PW'(v_s_r) + v_size - PW'(1);
    disj   = (v_s_r > hi_r) || (v_end < PW'(lo_r));
    full   = (lo_r <= v_s_r) && (v_end <= PW'(hi_r));
  end
  assign stat.partial = !disj && !full;
  assign is_toggle    = (cmd_t'(op_r) == CMD_TOGGLE);

  assign push_idx         = SIW'(sp_r);
  assign top_idx          = SIW'(sp_r - SPW'(1));
  assign stat.stack_empty = (sp_r == '0);
  assign top_ph           = stk_phase_r[top_idx];
  assign stat.top_phase   = top_ph;

  // Recombine the top frame from its two children
  always_comb begin
    top_size = PW'(1) << stk_lvl_r[top_idx];
    sum_c    = stk_lc_r[top_idx] + ret_cnt_r;
    fixed_c  = stk_flag_r[top_idx] ? (top_size - sum_c) : sum_c;
  end

  // Next-value logic of the walk
  always_comb begin
    v_node_nxt  = v_node_r;
    v_s_nxt     = v_s_r;
    v_lvl_nxt   = v_lvl_r;
    v_par_nxt   = v_par_r;
    sp_nxt      = sp_r;
    acc_nxt     = acc_r;
    ret_cnt_nxt = ret_cnt_r;
    outv_nxt    = 1'b0;
    outc_nxt    = outc_r;
    m_we        = 1'b0;
    m_waddr     = v_node_r;
    m_wdata     = '0;
    if (cmd.clear) begin
      m_we    = 1'b1;
      m_waddr = clr_addr_r;
    end
    if (cmd.load) begin
      v_node_nxt = AW'(1);
      v_s_nxt    = '0;
      v_lvl_nxt  = LW'(LOG);
      v_par_nxt  = 1'b0;
      sp_nxt     = '0;
      acc_nxt    = '0;
    end
    if (cmd.eval) begin
      ret_cnt_nxt = rcnt;
      if (full) begin
        if (is_toggle) begin
          m_we        = 1'b1;
          m_wdata     = {~rflag, v_size - rcnt};
          ret_cnt_nxt = v_size - rcnt;
        end else begin
          acc_nxt = acc_r + (v_par_r ? (v_size - rcnt) : rcnt);
        end
      end else if (!disj) begin
        // descend into the left child
        sp_nxt     = sp_r + SPW'(1);
        v_node_nxt = {v_node_r[AW-2:0], 1'b0};
        v_lvl_nxt  = v_lvl_r - LW'(1);
        v_par_nxt  = v_par_r ^ rflag;
      end
    end
    if (cmd.ret) begin
      if (stat.stack_empty) begin
        outv_nxt = !is_toggle;
        outc_nxt = OUT_W'(acc_r);
      end else if (!top_ph) begin
        // descend into the right child
        v_node_nxt = {stk_node_r[top_idx][AW-2:0], 1'b1};
        v_s_nxt    = stk_s_r[top_idx]
                   + LOG'((PW'(1) << stk_lvl_r[top_idx]) >> 1);
        v_lvl_nxt  = stk_lvl_r[top_idx] - LW'(1);
        v_par_nxt  = stk_cpar_r[top_idx];
      end else begin
        ret_cnt_nxt = fixed_c;
        sp_nxt      = sp_r - SPW'(1);
        if (is_toggle) begin
          m_we    = 1'b1;
          m_waddr = stk_node_r[top_idx];
          m_wdata = {stk_flag_r[top_idx], fixed_c};
        end
      end
    end
  end

  // Hold walk payload
  always_ff @(posedge clk) begin
    v_node_r  <= v_node_nxt;
    v_s_r     <= v_s_nxt;
    v_lvl_r   <= v_lvl_nxt;
    v_par_r   <= v_par_nxt;
    acc_r     <= acc_nxt;
    ret_cnt_r <= ret_cnt_nxt;
    outc_r    <= outc_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      outv_r <= 1'b0;
    end else begin
      sp_r   <= sp_nxt;
      outv_r <= outv_nxt;
    end
  end

  // Push a frame, or park the left child count
  always_ff @(posedge clk) begin
    if (cmd.eval && stat.partial) begin
      stk_node_r[push_idx]  <= v_node_r;
      stk_s_r[push_idx]     <= v_s_r;
      stk_lvl_r[push_idx]   <= v_lvl_r;
      stk_flag_r[push_idx]  <= rflag;
      stk_cpar_r[push_idx]  <= v_par_r ^ rflag;
      stk_phase_r[push_idx] <= 1'b0;
    end else if (cmd.ret && !stat.stack_empty && !top_ph) begin
      stk_lc_r[top_idx]    <= ret_cnt_r;
      stk_phase_r[top_idx] <= 1'b1;
    end
  end

  assign out_valid    = outv_r;
  assign out_on_count = outc_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_toggle_count_tree: items are sent in random
// bursts, every count is predicted by a lazy flip tree of the bench's own and
// each out_valid strobe is compared with the oldest predicted count.
// ----------------------------------------------------------------------------
module tb_top;
  import rtct_pkg::*;

  localparam int unsigned LEAVES    = DEF_NUM_LEAVES;
  localparam int unsigned SETTLE    = 600;
  localparam longint      CYC_LIMIT = 4000000;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_cmd;
  logic [POS_W-1:0] in_range_first;
  logic [POS_W-1:0] in_range_last;
  logic             out_valid;
  logic [OUT_W-1:0] out_on_count;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_active_len;

  // Shadow tree: ones-count and flip mark per node, root at index 1
  int unsigned      ones_cnt [2*LEAVES];
  bit               flip_mark[2*LEAVES];
  logic [LEN_W-1:0] len_shadow;

  logic [OUT_W-1:0] count_q[$];
  int unsigned      mismatches;
  longint           cycles;
  int unsigned      burst_left;

  range_toggle_count_tree #(.NUM_LEAVES(LEAVES)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_range_first(in_range_first),
    .in_range_last (in_range_last),
    .out_valid     (out_valid),
    .out_on_count  (out_on_count),
    .cfg_we        (cfg_we),
    .cfg_active_len(cfg_active_len)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---- shadow tree ---------------------------------------------------------
  // Invert a whole node and mark its children
  function automatic void node_invert(int unsigned node, int unsigned s, int unsigned e);
    ones_cnt[node] = (e - s + 1) - ones_cnt[node];
    if (s != e) flip_mark[node] = ~flip_mark[node];
  endfunction

  // Hand a pending flip down to both children
  function automatic void node_push(int unsigned node, int unsigned s, int unsigned e);
    int unsigned mid;
    mid = (s + e) >> 1;
    if (flip_mark[node] && s != e) begin
      node_invert(2*node, s, mid);
      node_invert(2*node + 1, mid + 1, e);
      flip_mark[node] = 1'b0;
    end
  endfunction

  function automatic void tree_flip(int unsigned node, int unsigned s, int unsigned e,
                                    int unsigned lo, int unsigned hi);
    int unsigned mid;
    mid = (s + e) >> 1;
    if (s > hi || e < lo) return;
    if (lo <= s && e <= hi) begin
      node_invert(node, s, e);
      return;
    end
    node_push(node, s, e);
    tree_flip(2*node, s, mid, lo, hi);
    tree_flip(2*node + 1, mid + 1, e, lo, hi);
    ones_cnt[node] = ones_cnt[2*node] + ones_cnt[2*node + 1];
  endfunction

  function automatic int unsigned tree_ones(int unsigned node, int unsigned s,
                                            int unsigned e, int unsigned lo,
                                            int unsigned hi);
    int unsigned mid;
    mid = (s + e) >> 1;
    if (s > hi || e < lo) return 0;
    if (lo <= s && e <= hi) return ones_cnt[node];
    node_push(node, s, e);
    return tree_ones(2*node, s, mid, lo, hi) + tree_ones(2*node + 1, mid + 1, e, lo, hi);
  endfunction

  // Clip the range to the active length and apply one accepted item
  function automatic void predict_item(logic cmd, logic [POS_W-1:0] first,
                                       logic [POS_W-1:0] last);
    int unsigned len, lo, hi, total;
    len = (len_shadow > LEAVES) ? LEAVES : len_shadow;
    lo  = (first == 0) ? 1 : first;
    hi  = (last > len) ? len : last;
    total = 0;
    if (len != 0 && lo <= hi) begin
      if (cmd == CMD_TOGGLE) tree_flip(1, 0, LEAVES - 1, lo - 1, hi - 1);
      else total = tree_ones(1, 0, LEAVES - 1, lo - 1, hi - 1);
    end
    if (cmd == CMD_COUNT) count_q.push_back(OUT_W'(total));
  endfunction

  // ---- result checker ------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (count_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: on_count %0d", out_on_count);
      end else begin
        if (out_on_count !== count_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("on_count mismatch: expected %0d, got %0d", count_q[0], out_on_count);
        end
        void'(count_q.pop_front());
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---- stimulus helpers ----------------------------------------------------
  // Present one item, hold it until accepted, then gap or continue the burst
  task automatic send_item(logic cmd, logic [POS_W-1:0] first, logic [POS_W-1:0] last);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_range_first <= first;
    in_range_last  <= last;
    do @(posedge clk); while (busy);
    predict_item(cmd, first, last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Hold off until every count is back and the block has gone quiet
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (count_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    wait_idle();
    cfg_we         <= 1'b1;
    cfg_active_len <= len;
    @(posedge clk);
    cfg_we     <= 1'b0;
    len_shadow  = len;
    @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_pos(int unsigned len);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return POS_W'($urandom_range(0, POS_MAX));
    if (len == 0) return POS_W'($urandom_range(0, 8));
    return POS_W'($urandom_range(1, len));
  endfunction

  // ---- tests ---------------------------------------------------------------
  task automatic test_directed();
    send_item(CMD_COUNT, 1, POS_W'(LEAVES));
    send_item(CMD_TOGGLE, 1, POS_W'(LEAVES));
    send_item(CMD_COUNT, 1, POS_W'(LEAVES));
    send_item(CMD_COUNT, 0, POS_MAX);
    send_item(CMD_TOGGLE, 0, 1);
    send_item(CMD_COUNT, 1, 2);
    send_item(CMD_TOGGLE, 100, 50);
    send_item(CMD_COUNT, 100, 50);
    send_item(CMD_TOGGLE, POS_W'(LEAVES), POS_MAX);
    send_item(CMD_COUNT, POS_W'(LEAVES - 1), POS_W'(LEAVES));
    send_item(CMD_TOGGLE, 3, 3);
    send_item(CMD_COUNT, 0, 0);
    send_item(CMD_COUNT, POS_MAX, POS_MAX);
    send_item(CMD_TOGGLE, 2, POS_W'(LEAVES - 1));
    send_item(CMD_COUNT, 1, POS_W'(LEAVES));
  endtask

  // Length extremes, including the bits kept beyond a shrunk length
  task automatic test_length_edges();
    set_length(1);
    send_item(CMD_COUNT, 0, POS_MAX);
    send_item(CMD_TOGGLE, 1, POS_MAX);
    send_item(CMD_COUNT, 1, 2);
    set_length(0);
    send_item(CMD_TOGGLE, 1, 10);
    send_item(CMD_COUNT, 1, 10);
    set_length(LEN_W'(POS_MAX));
    send_item(CMD_COUNT, 1, POS_MAX);
    set_length(LEN_W'(LEAVES));
    send_item(CMD_COUNT, 1, 8);
  endtask

  task automatic test_random(int unsigned n_items);
    logic [POS_W-1:0] a, b;
    int unsigned      len;
    len = (len_shadow > LEAVES) ? LEAVES : len_shadow;
    for (int unsigned k = 0; k < n_items; k++) begin
      a = pick_pos(len);
      if ($urandom_range(0, 3) == 0) b = a + POS_W'($urandom_range(0, 15));
      else b = pick_pos(len);
      if ($urandom_range(0, 9) != 0 && a > b) begin
        logic [POS_W-1:0] t;
        t = a; a = b; b = t;
      end
      send_item(logic'($urandom_range(0, 1)), a, b);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_cmd         <= CMD_TOGGLE;
    in_range_first <= '0;
    in_range_last  <= '0;
    cfg_we         <= 1'b0;
    cfg_active_len <= RST_ACTIVE_LEN;
    len_shadow      = RST_ACTIVE_LEN;
    mismatches      = 0;
    cycles          = 0;
    burst_left      = 0;
    for (int unsigned k = 0; k < 2*LEAVES; k++) begin
      ones_cnt[k]  = 0;
      flip_mark[k] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_length_edges();
    test_random(540);
    set_length(37);
    test_random(300);
    set_length(LEN_W'($urandom_range(2, LEAVES - 1)));
    test_random(300);
    set_length(LEN_W'(LEAVES));
    test_random(500);

    wait_idle();
    if (mismatches == 0 && count_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
